>>> rtl/core/pfn_pkg.sv
// shared types, permutation table and fixed-point helpers for the octave noise pipeline
package pfn_pkg;

  // signed q.16 value with room for the gradient and interpolation ranges
  typedef logic signed [21:0] q_t;

  localparam q_t ONE_Q = 22'sd65536;
  localparam q_t FADE_C15 = 22'sd983040;
  localparam q_t FADE_C10 = 22'sd655360;
  localparam q_t FADE_MUL6 = 22'sd6;

  // width of the octave sum before saturation
  localparam int SUMW = 27;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
    8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
    8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230,
    8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187,
    8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42,
    8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,
    8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176,
    8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66,
    8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  // q.16 product, floored
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [43:0] p;
    p = a * b;
    return p[37:16];
  endfunction

  function automatic q_t lerp(input q_t w, input q_t a, input q_t b);
    q_t diff;
    diff = b - a;
    return a + qmul(w, diff);
  endfunction

  function automatic q_t grad(input logic [3:0] h, input q_t x, input q_t y, input q_t z);
    q_t u;
    q_t v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

>>> rtl/core/pfn_noise.sv
// eight-stage gradient noise pipeline for one octave
module pfn_noise #(
  parameter int OCT = 0,
  parameter int FRAC = 24
) (
  input  logic         clk,
  input  logic         en,
  input  logic [31:0]  coord_x,
  input  logic [31:0]  coord_y,
  input  logic [31:0]  coord_z,
  output pfn_pkg::q_t  noise
);

  logic [31:0] crd [3];
  logic [63:0] scaled [3];
  logic [7:0]  lat [3];
  logic [15:0] frac [3];

  // stage registers
  logic [15:0]  fr1 [3];
  pfn_pkg::q_t  c1 [3];
  logic [7:0]   cy1, cz1, px0, px1;
  logic [15:0]  fr2 [3];
  pfn_pkg::q_t  d2 [3];
  logic [7:0]   cz2, pa0, pa1, pb0, pb1;
  logic [15:0]  fr3 [3];
  pfn_pkg::q_t  e3 [3];
  logic [3:0]   h3 [8];
  logic [15:0]  fr4 [3];
  pfn_pkg::q_t  g4 [3];
  pfn_pkg::q_t  gr4 [8];
  pfn_pkg::q_t  f5 [3];
  pfn_pkg::q_t  gr5 [8];
  pfn_pkg::q_t  l6 [4];
  pfn_pkg::q_t  fv6, fw6;
  pfn_pkg::q_t  l7 [2];
  pfn_pkg::q_t  fw7;

  logic [7:0]   base [4];
  logic [7:0]   hsh [8];
  pfn_pkg::q_t  lo [3];
  pfn_pkg::q_t  hi [3];

  assign crd[0] = coord_x;
  assign crd[1] = coord_y;
  assign crd[2] = coord_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scaled[k] = {32'b0, crd[k]} << OCT;
      lat[k]    = scaled[k][FRAC+7:FRAC];
      frac[k]   = scaled[k][FRAC-1:FRAC-16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fr1[k] <= frac[k];
        c1[k]  <= pfn_pkg::q_t'({6'b0, frac[k]}) * pfn_pkg::FADE_MUL6 - pfn_pkg::FADE_C15;
      end
      cy1 <= lat[1];
      cz1 <= lat[2];
      px0 <= pfn_pkg::perm(lat[0]);
      px1 <= pfn_pkg::perm(8'(lat[0] + 8'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fr2[k] <= fr1[k];
        d2[k]  <= pfn_pkg::qmul(pfn_pkg::q_t'({6'b0, fr1[k]}), c1[k]) + pfn_pkg::FADE_C10;
      end
      cz2 <= cz1;
      pa0 <= pfn_pkg::perm(8'(px0 + cy1));
      pa1 <= pfn_pkg::perm(8'(px0 + cy1 + 8'd1));
      pb0 <= pfn_pkg::perm(8'(px1 + cy1));
      pb1 <= pfn_pkg::perm(8'(px1 + cy1 + 8'd1));
    end
  end

  // corner hash bases in the order AA, BA, AB, BB
  always_comb begin
    base[0] = 8'(pa0 + cz2);
    base[1] = 8'(pb0 + cz2);
    base[2] = 8'(pa1 + cz2);
    base[3] = 8'(pb1 + cz2);
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      hsh[k] = pfn_pkg::perm(8'(base[k & 3] + 8'(k >> 2)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fr3[k] <= fr2[k];
        e3[k]  <= pfn_pkg::qmul(pfn_pkg::q_t'({6'b0, fr2[k]}), d2[k]);
      end
      for (int k = 0; k < 8; k++) begin
        h3[k] <= hsh[k][3:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = pfn_pkg::q_t'({6'b0, fr3[k]});
      hi[k] = lo[k] - pfn_pkg::ONE_Q;
    end
  end

  // corner bit 0 picks x-1, bit 1 y-1, bit 2 z-1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fr4[k] <= fr3[k];
        g4[k]  <= pfn_pkg::qmul(pfn_pkg::q_t'({6'b0, fr3[k]}), e3[k]);
      end
      for (int k = 0; k < 8; k++) begin
        gr4[k] <= pfn_pkg::grad(h3[k], k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                k[2] ? hi[2] : lo[2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f5[k] <= pfn_pkg::qmul(pfn_pkg::q_t'({6'b0, fr4[k]}), g4[k]);
      end
      gr5 <= gr4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        l6[j] <= pfn_pkg::lerp(f5[0], gr5[2*j], gr5[2*j+1]);
      end
      fv6 <= f5[1];
      fw6 <= f5[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 2; m++) begin
        l7[m] <= pfn_pkg::lerp(fv6, l6[2*m], l6[2*m+1]);
      end
      fw7 <= fw6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise <= pfn_pkg::lerp(fw7, l7[0], l7[1]);
    end
  end

endmodule

>>> rtl/core/pfn_accum.sv
// weighted octave sum over a registered adder tree, saturation and byte mapping
module pfn_accum #(
  parameter int OCTAVES_MAX = 15
) (
  input  logic               clk,
  input  logic               en,
  input  logic [3:0]         octave_count,
  input  pfn_pkg::q_t        noise [OCTAVES_MAX],
  output logic signed [17:0] noise_sum,
  output logic [7:0]         noise_byte
);

  localparam int NG = (OCTAVES_MAX + 3) / 4;

  logic [4:0] neff;
  logic signed [pfn_pkg::SUMW-1:0] term [OCTAVES_MAX];
  logic signed [pfn_pkg::SUMW-1:0] grp [NG];
  logic signed [pfn_pkg::SUMW-1:0] part [NG];
  logic signed [pfn_pkg::SUMW-1:0] total;
  logic signed [17:0] sum_sat;
  logic signed [17:0] sum_b;
  logic signed [18:0] off;
  logic signed [27:0] prod;
  logic [7:0] byte_val;

  // zero octaves counts as one, more than the pipeline holds is clipped
  always_comb begin
    if (octave_count == 4'd0) begin
      neff = 5'd1;
    end else if ({1'b0, octave_count} > 5'(OCTAVES_MAX)) begin
      neff = 5'(OCTAVES_MAX);
    end else begin
      neff = {1'b0, octave_count};
    end
  end

  // arithmetic shift floors the weighted octave term
  always_comb begin
    for (int i = 0; i < OCTAVES_MAX; i++) begin
      term[i] = '0;
      if (5'(i) < neff) begin
        term[i] = pfn_pkg::SUMW'(noise[i]) >>> (i + 1);
      end
    end
    for (int g = 0; g < NG; g++) begin
      grp[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < OCTAVES_MAX) begin
          grp[g] = grp[g] + term[4*g+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part <= grp;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NG; g++) begin
      total = total + part[g];
    end
    if (total > pfn_pkg::SUMW'(131071)) begin
      sum_sat = 18'sh1ffff;
    end else if (total < -pfn_pkg::SUMW'(131072)) begin
      sum_sat = -18'sh20000;
    end else begin
      sum_sat = total[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_b <= sum_sat;
    end
  end

  // 255 * (sum + 1.0 in q.16) / 2^17, clipped to a byte
  always_comb begin
    off  = 19'(sum_b) + 19'sd65536;
    prod = 28'(off) * 28'sd255;
    if (prod < 0) begin
      byte_val = 8'd0;
    end else if (prod[26:17] > 10'd255) begin
      byte_val = 8'd255;
    end else begin
      byte_val = prod[24:17];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise_sum  <= sum_b;
      noise_byte <= byte_val;
    end
  end

endmodule

>>> rtl/core/perlin_fbm_noise_3d.sv
// from input acceptance to result valid an item passes 8 noise stages and 3 sum stages
// throughput: one item per cycle unless the pipeline holds; each octave has its own noise pipeline
// the whole pipeline holds while a finished result waits and m_tready is low
// reset clears the stage valid bits and sets octave_count to 15
// top level: octave noise pipelines, sum stages, apb register
module perlin_fbm_noise_3d #(
  parameter int OCTAVES_MAX = 15,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // noise_sum[17:0], noise_byte[25:18], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAT = 11;

  logic [3:0] octave_count;
  logic adv;
  logic [LAT-1:0] vld;
  pfn_pkg::q_t noise [OCTAVES_MAX];
  logic signed [17:0] noise_sum;
  logic [7:0] noise_byte;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'b0, octave_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd15;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      octave_count <= pwdata[3:0];
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {6'b0, noise_byte, noise_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  for (genvar i = 0; i < OCTAVES_MAX; i++) begin : g_oct
    pfn_noise #(
      .OCT(i),
      .FRAC(COORD_FRAC_BITS)
    ) u_noise (
      .clk(clk),
      .en(adv),
      .coord_x(s_tdata[31:0]),
      .coord_y(s_tdata[63:32]),
      .coord_z(s_tdata[95:64]),
      .noise(noise[i])
    );
  end

  pfn_accum #(
    .OCTAVES_MAX(OCTAVES_MAX)
  ) u_accum (
    .clk(clk),
    .en(adv),
    .octave_count(octave_count),
    .noise(noise),
    .noise_sum(noise_sum),
    .noise_byte(noise_byte)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (vld == $past(vld)))
    else $error("stage valid bits moved during a stall");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == 1'b0) |=> (octave_count == $past(pwdata[3:0])))
    else $error("octave count write lost");

  a_low_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && noise_sum <= -18'sd65536) |-> (noise_byte == 8'd0))
    else $error("byte not zero for low sum");

endmodule
